// ----- hw/rtl/gbps_pkg.sv -----
// Shared types and codes for the gain bucket priority store.
`default_nettype none
package gbps_pkg;

  // Operation carried in the input transaction's tuser.
  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_POP    = 2'd1,
    FN_UPDATE = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  // Result status carried in the output transaction's tuser.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_NREAD,
    S_NCHK,
    S_SCAN,
    S_PREAD,
    S_PNODE,
    S_PLINK,
    S_REMOVE,
    S_IREAD,
    S_IHEAD,
    S_ILINK,
    S_DONE
  } state_t;

  // Signed width for bucket arithmetic, wide enough for the largest store.
  localparam int ARITH_W = 14;
  // Occupancy bits examined per scan step.
  localparam int SCAN_W = 8;

endpackage
`default_nettype wire

// ----- hw/rtl/gain_bucket_priority_store.sv -----
// Gain bucket priority store: per-gain doubly linked lists of nodes.
//
// Input channel in_*: tuser holds the operation (add, pop highest, update,
// query); tdata holds node, gain, delta and at_head. Output channel out_*:
// one result transaction per input transaction, status in tuser.
// A single sequencer walks each operation through node and bucket memories
// with one write and one read port and registered reads, so in_tready is
// high only between items. A query reads and checks the node; an add then
// reads the bucket and links the node in, with an extra link step when the
// bucket already holds nodes; an update unlinks the node, then inserts it
// likewise; a pop scans the occupancy bits in groups of eight from the top
// and unlinks the head or tail node of the first occupied bucket. With the
// receiver ready, the next item is accepted the cycle after the result loads.
// After reset a clearing pass wipes the presence memory one entry at a time;
// no input is taken until it ends.
// The result sits in an output register. A new item is accepted while that
// result waits; the next result is held back until the receiver takes the
// previous one.
`default_nettype none
module gain_bucket_priority_store #(
  parameter int NODE_COUNT   = 1024,
  parameter int GAIN_BUCKETS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // node[9:0], gain[17:10], delta[26:18], at_head[27], zero[31:28]
  input  wire logic [31:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_node[9:0], out_gain[17:10], store_empty[18], zero[23:19]
  output logic [23:0]      out_tdata,
  // status[2:0]
  output logic [2:0]       out_tuser
);

  localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LW  = $clog2(NODE_COUNT + 1);
  localparam int BW  = $clog2(GAIN_BUCKETS);
  localparam int CNW = $clog2(NODE_COUNT + 1);
  localparam int OFF = GAIN_BUCKETS / 2;
  localparam int NCH = (GAIN_BUCKETS + gbps_pkg::SCAN_W - 1) / gbps_pkg::SCAN_W;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW  = gbps_pkg::ARITH_W;
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

  gbps_pkg::state_t state_r, state_nxt;

  gbps_pkg::func_t    fn_r, fn_nxt;
  logic [NW-1:0]      node_r, node_nxt;
  logic [7:0]         gain_in_r, gain_in_nxt;
  logic [8:0]         delta_r, delta_nxt;
  logic               head_r, head_nxt;
  logic [BW-1:0]      cur_bkt_r, cur_bkt_nxt;
  logic [BW-1:0]      new_bkt_r, new_bkt_nxt;
  logic [LW-1:0]      nx_r, nx_nxt;
  logic [LW-1:0]      pv_r, pv_nxt;
  logic [LW-1:0]      nbr_r, nbr_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [NW-1:0]      clr_r, clr_nxt;
  logic [GAIN_BUCKETS-1:0] occ_r, occ_nxt;
  logic [CNW-1:0]     cnt_r, cnt_nxt;
  logic [9:0]         res_node_r, res_node_nxt;
  logic [7:0]         res_gain_r, res_gain_nxt;
  gbps_pkg::status_t  res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        out_data_r, out_data_nxt;
  logic [2:0]         out_user_r, out_user_nxt;

  // Node memories.
  logic              present_mem [NODE_COUNT];
  logic [BW-1:0]     gain_mem    [NODE_COUNT];
  logic [LW-1:0]     next_mem    [NODE_COUNT];
  logic [LW-1:0]     prev_mem    [NODE_COUNT];
  // Bucket memories.
  logic [LW-1:0]     head_mem    [GAIN_BUCKETS];
  logic [LW-1:0]     tail_mem    [GAIN_BUCKETS];

  logic              pres_q;
  logic [BW-1:0]     gain_q;
  logic [LW-1:0]     next_q, prev_q, head_q, tail_q;

  logic [NW-1:0]     nd_ra;
  logic [BW-1:0]     bk_ra;
  logic              pm_we, pm_wd;
  logic [NW-1:0]     pm_wa;
  logic              gm_we;
  logic [NW-1:0]     gm_wa;
  logic [BW-1:0]     gm_wd;
  logic              nm_we, vm_we;
  logic [NW-1:0]     nm_wa, vm_wa;
  logic [LW-1:0]     nm_wd, vm_wd;
  logic              hm_we, tm_we;
  logic [BW-1:0]     hm_wa, tm_wa;
  logic [LW-1:0]     hm_wd, tm_wd;

  logic                       accept;
  logic                       load_out;
  logic signed [AW-1:0]       add_b, upd_b;
  logic                       add_ok, upd_ok;
  logic [NCH*gbps_pkg::SCAN_W-1:0] occ_pad;
  logic [gbps_pkg::SCAN_W-1:0] chunk;
  logic                       chunk_hit;
  logic [2:0]                 chunk_bit;
  logic [BW-1:0]              scan_b;
  logic                       occ_new;
  logic [LW-1:0]              pop_n;
  logic [LW-1:0]              node_link;

  assign in_tready  = (state_r == gbps_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign load_out   = (state_r == gbps_pkg::S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign add_b  = AW'(signed'(gain_in_r)) + AW'(OFF);
  assign upd_b  = AW'(signed'({1'b0, gain_q})) + AW'(signed'(delta_r));
  assign add_ok = !add_b[AW-1] && (add_b < AW'(GAIN_BUCKETS));
  assign upd_ok = !upd_b[AW-1] && (upd_b < AW'(GAIN_BUCKETS));
  assign occ_new   = occ_r[new_bkt_r];
  assign pop_n     = head_r ? head_q : tail_q;
  assign node_link = LW'(node_r);

  always_comb begin
    for (int i = 0; i < NCH * gbps_pkg::SCAN_W; i++) begin
      occ_pad[i] = (i < GAIN_BUCKETS) ? occ_r[i % GAIN_BUCKETS] : 1'b0;
    end
  end

  // Highest occupied bucket within the current group of eight.
  always_comb begin
    chunk     = occ_pad[ptr_r*gbps_pkg::SCAN_W +: gbps_pkg::SCAN_W];
    chunk_hit = 1'b0;
    chunk_bit = 3'd0;
    for (int k = 0; k < gbps_pkg::SCAN_W; k++) begin
      if (chunk[k]) begin
        chunk_hit = 1'b1;
        chunk_bit = 3'(k);
      end
    end
  end
  assign scan_b = BW'({ptr_r, chunk_bit});

  // Memory read addresses.
  always_comb begin
    nd_ra = (state_r == gbps_pkg::S_PNODE) ? NW'(pop_n) : node_r;
    bk_ra = (state_r == gbps_pkg::S_PREAD) ? cur_bkt_r : new_bkt_r;
  end

  always_ff @(posedge clk) begin
    if (pm_we) present_mem[pm_wa] <= pm_wd;
    pres_q <= present_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (gm_we) gain_mem[gm_wa] <= gm_wd;
    gain_q <= gain_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (nm_we) next_mem[nm_wa] <= nm_wd;
    next_q <= next_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (vm_we) prev_mem[vm_wa] <= vm_wd;
    prev_q <= prev_mem[nd_ra];
  end
  always_ff @(posedge clk) begin
    if (hm_we) head_mem[hm_wa] <= hm_wd;
    head_q <= head_mem[bk_ra];
  end
  always_ff @(posedge clk) begin
    if (tm_we) tail_mem[tm_wa] <= tm_wd;
    tail_q <= tail_mem[bk_ra];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbps_pkg::S_CLEAR: begin
        if (clr_r == NW'(NODE_COUNT - 1)) state_nxt = gbps_pkg::S_IDLE;
      end
      gbps_pkg::S_IDLE: begin
        if (accept) begin
          if (gbps_pkg::func_t'(in_tuser) == gbps_pkg::FN_POP) begin
            state_nxt = gbps_pkg::S_SCAN;
          end else if (17'(in_tdata[9:0]) < 17'(NODE_COUNT)) begin
            state_nxt = gbps_pkg::S_NREAD;
          end else begin
            state_nxt = gbps_pkg::S_DONE;
          end
        end
      end
      gbps_pkg::S_NREAD: state_nxt = gbps_pkg::S_NCHK;
      gbps_pkg::S_NCHK: begin
        state_nxt = gbps_pkg::S_DONE;
        if (fn_r == gbps_pkg::FN_ADD) begin
          if (!pres_q && add_ok) state_nxt = gbps_pkg::S_IREAD;
        end else if (fn_r == gbps_pkg::FN_UPDATE) begin
          if (pres_q && upd_ok) state_nxt = gbps_pkg::S_REMOVE;
        end
      end
      gbps_pkg::S_SCAN: begin
        if (chunk_hit) state_nxt = gbps_pkg::S_PREAD;
        else if (ptr_r == '0) state_nxt = gbps_pkg::S_DONE;
      end
      gbps_pkg::S_PREAD:  state_nxt = gbps_pkg::S_PNODE;
      gbps_pkg::S_PNODE:  state_nxt = gbps_pkg::S_PLINK;
      gbps_pkg::S_PLINK:  state_nxt = gbps_pkg::S_REMOVE;
      gbps_pkg::S_REMOVE: begin
        state_nxt = (fn_r == gbps_pkg::FN_UPDATE) ? gbps_pkg::S_IREAD : gbps_pkg::S_DONE;
      end
      gbps_pkg::S_IREAD: state_nxt = gbps_pkg::S_IHEAD;
      gbps_pkg::S_IHEAD: state_nxt = occ_new ? gbps_pkg::S_ILINK : gbps_pkg::S_DONE;
      gbps_pkg::S_ILINK: state_nxt = gbps_pkg::S_DONE;
      gbps_pkg::S_DONE: begin
        if (load_out) state_nxt = gbps_pkg::S_IDLE;
      end
      default: state_nxt = gbps_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory writes and result register.
  always_comb begin
    fn_nxt       = fn_r;
    node_nxt     = node_r;
    gain_in_nxt  = gain_in_r;
    delta_nxt    = delta_r;
    head_nxt     = head_r;
    cur_bkt_nxt  = cur_bkt_r;
    new_bkt_nxt  = new_bkt_r;
    nx_nxt       = nx_r;
    pv_nxt       = pv_r;
    nbr_nxt      = nbr_r;
    ptr_nxt      = ptr_r;
    clr_nxt      = clr_r;
    occ_nxt      = occ_r;
    cnt_nxt      = cnt_r;
    res_node_nxt = res_node_r;
    res_gain_nxt = res_gain_r;
    res_st_nxt   = res_st_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pm_we = 1'b0; pm_wa = node_r; pm_wd = 1'b0;
    gm_we = 1'b0; gm_wa = node_r; gm_wd = new_bkt_r;
    nm_we = 1'b0; nm_wa = node_r; nm_wd = NIL;
    vm_we = 1'b0; vm_wa = node_r; vm_wd = NIL;
    hm_we = 1'b0; hm_wa = new_bkt_r; hm_wd = node_link;
    tm_we = 1'b0; tm_wa = new_bkt_r; tm_wd = node_link;

    case (state_r)
      gbps_pkg::S_CLEAR: begin
        pm_we   = 1'b1;
        pm_wa   = clr_r;
        clr_nxt = clr_r + NW'(1);
      end
      gbps_pkg::S_IDLE: begin
        if (accept) begin
          fn_nxt       = gbps_pkg::func_t'(in_tuser);
          node_nxt     = NW'(in_tdata[9:0]);
          gain_in_nxt  = in_tdata[17:10];
          delta_nxt    = in_tdata[26:18];
          head_nxt     = in_tdata[27];
          ptr_nxt      = CW'(NCH - 1);
          res_node_nxt = in_tdata[9:0];
          res_gain_nxt = 8'd0;
          res_st_nxt   = gbps_pkg::ST_OK;
          if (gbps_pkg::func_t'(in_tuser) != gbps_pkg::FN_POP &&
              !(17'(in_tdata[9:0]) < 17'(NODE_COUNT))) begin
            res_st_nxt = gbps_pkg::ST_ABSENT;
          end
        end
      end
      gbps_pkg::S_NCHK: begin
        cur_bkt_nxt = gain_q;
        nx_nxt      = next_q;
        pv_nxt      = prev_q;
        if (fn_r == gbps_pkg::FN_ADD) begin
          if (pres_q) begin
            res_st_nxt = gbps_pkg::ST_PRESENT;
          end else if (!add_ok) begin
            res_st_nxt = gbps_pkg::ST_RANGE;
          end else begin
            new_bkt_nxt  = BW'(add_b);
            res_gain_nxt = gain_in_r;
          end
        end else if (!pres_q) begin
          res_st_nxt = gbps_pkg::ST_ABSENT;
        end else if (fn_r == gbps_pkg::FN_UPDATE) begin
          if (!upd_ok) begin
            res_st_nxt = gbps_pkg::ST_RANGE;
          end else begin
            new_bkt_nxt  = BW'(upd_b);
            head_nxt     = 1'b1;
            res_gain_nxt = 8'(upd_b - AW'(OFF));
          end
        end else begin
          res_gain_nxt = 8'(AW'({1'b0, gain_q}) - AW'(OFF));
        end
      end
      gbps_pkg::S_SCAN: begin
        if (chunk_hit) begin
          cur_bkt_nxt  = scan_b;
          res_gain_nxt = 8'(AW'({1'b0, scan_b}) - AW'(OFF));
        end else if (ptr_r == '0) begin
          res_st_nxt   = gbps_pkg::ST_EMPTY;
          res_node_nxt = 10'd0;
        end else begin
          ptr_nxt = ptr_r - CW'(1);
        end
      end
      gbps_pkg::S_PNODE: begin
        node_nxt     = NW'(pop_n);
        res_node_nxt = 10'(pop_n);
      end
      gbps_pkg::S_PLINK: begin
        nx_nxt = next_q;
        pv_nxt = prev_q;
      end
      gbps_pkg::S_REMOVE: begin
        // Unlink the node from its bucket; both neighbors or ends are written in this state.
        if (nx_r == NIL) begin
          tm_we = 1'b1; tm_wa = cur_bkt_r; tm_wd = pv_r;
        end else begin
          vm_we = 1'b1; vm_wa = NW'(nx_r); vm_wd = pv_r;
        end
        if (pv_r == NIL) begin
          hm_we = 1'b1; hm_wa = cur_bkt_r; hm_wd = nx_r;
        end else begin
          nm_we = 1'b1; nm_wa = NW'(pv_r); nm_wd = nx_r;
        end
        if (nx_r == NIL && pv_r == NIL) occ_nxt[cur_bkt_r] = 1'b0;
        cnt_nxt = cnt_r - CNW'(1);
        if (fn_r == gbps_pkg::FN_POP) begin
          pm_we = 1'b1;
          pm_wd = 1'b0;
        end
      end
      gbps_pkg::S_IHEAD: begin
        gm_we = 1'b1;
        pm_we = 1'b1;
        pm_wd = 1'b1;
        nm_we = 1'b1;
        vm_we = 1'b1;
        occ_nxt[new_bkt_r] = 1'b1;
        cnt_nxt = cnt_r + CNW'(1);
        nbr_nxt = head_r ? head_q : tail_q;
        if (!occ_new) begin
          hm_we = 1'b1;
          tm_we = 1'b1;
        end else if (head_r) begin
          nm_wd = head_q;
          hm_we = 1'b1;
        end else begin
          vm_wd = tail_q;
          tm_we = 1'b1;
        end
      end
      gbps_pkg::S_ILINK: begin
        if (head_r) begin
          vm_we = 1'b1; vm_wa = NW'(nbr_r); vm_wd = node_link;
        end else begin
          nm_we = 1'b1; nm_wa = NW'(nbr_r); nm_wd = node_link;
        end
      end
      gbps_pkg::S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, (cnt_r == '0), res_gain_r, res_node_r};
          out_user_nxt  = res_st_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbps_pkg::S_CLEAR;
      clr_r       <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fn_r       <= fn_nxt;
    node_r     <= node_nxt;
    gain_in_r  <= gain_in_nxt;
    delta_r    <= delta_nxt;
    head_r     <= head_nxt;
    cur_bkt_r  <= cur_bkt_nxt;
    new_bkt_r  <= new_bkt_nxt;
    nx_r       <= nx_nxt;
    pv_r       <= pv_nxt;
    nbr_r      <= nbr_nxt;
    ptr_r      <= ptr_nxt;
    res_node_r <= res_node_nxt;
    res_gain_r <= res_gain_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gbps_checker.sv -----
// Port-level checks for the gain bucket priority store, bound to the top level.
`default_nettype none
module gbps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // A stalled result transaction keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Any failed operation reports a zero gain.
  a_err_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != gbps_pkg::ST_OK |-> out_tdata[17:10] == 8'd0)
    else $error("nonzero gain on error");

  // A pop on an empty store gives node zero and reports the store empty.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gbps_pkg::ST_EMPTY |->
      out_tdata[9:0] == 10'd0 && out_tdata[18])
    else $error("bad empty pop result");

  // A node found already present means the store cannot be empty.
  a_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gbps_pkg::ST_PRESENT |-> !out_tdata[18])
    else $error("store empty while node present");

endmodule

bind gain_bucket_priority_store gbps_checker u_gbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
